>>> src/leso_pkg.sv
// Shared constants for the linear extended state observer: field widths,
// register map codes and register reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package leso_pkg;

    // Default state format, signed Q24.24 in 48 bits
    localparam int STATE_WIDTH_DEF = 48;
    localparam int STATE_FRAC_DEF  = 24;

    // Field widths
    localparam int WORD_W     = 32;
    localparam int GAIN_W     = 48;
    localparam int CFG_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;

    // Multiplier datapath: signed operands, magnitudes, limbs, accumulator
    localparam int OPER_W = 65;
    localparam int MAG_W  = 64;
    localparam int LIMB_W = 32;
    localparam int ACC_W  = 128;

    // Register indexes (byte address 8*i)
    localparam logic [REG_IDX_W-1:0] REG_GAIN_ONE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_TWO   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_THREE = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PLANT_GAIN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STEP_TIME  = 3'd4;

    // Reset values: beta1 = 30, beta2 = 300, beta3 = 1000, b0 = 1, dt = 0.01
    localparam logic [GAIN_W-1:0] GAIN_ONE_RST   = 48'd1966080;
    localparam logic [GAIN_W-1:0] GAIN_TWO_RST   = 48'd19660800;
    localparam logic [GAIN_W-1:0] GAIN_THREE_RST = 48'd65536000;
    localparam logic [WORD_W-1:0] PLANT_GAIN_RST = 32'd65536;
    localparam logic [WORD_W-1:0] STEP_TIME_RST  = 32'd42949673;

endpackage

`default_nettype wire

>>> src/leso_if.sv
// Valid/ready channel interfaces for observer samples and estimates.
// Depends on leso_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface leso_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [leso_pkg::WORD_W-1:0]  measured;
    logic signed [leso_pkg::WORD_W-1:0]  drive;
    logic                                clear;

    modport source (output valid, measured, drive, clear, input ready);
    modport sink   (input valid, measured, drive, clear, output ready);
endinterface

interface leso_result_if #(
    parameter int STATE_WIDTH = leso_pkg::STATE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [STATE_WIDTH-1:0] out_position;
    logic signed [STATE_WIDTH-1:0] out_rate;
    logic signed [STATE_WIDTH-1:0] out_disturbance;
    logic                          saturated;

    modport source (output valid, out_position, out_rate, out_disturbance, saturated,
                    input ready);
    modport sink   (input valid, out_position, out_rate, out_disturbance, saturated,
                    output ready);
endinterface

`default_nettype wire

>>> src/linear_extended_state_observer_unit.sv
// Third-order linear extended state observer with a shared 32x32 multiplier
// and a shared saturating adder under a step sequencer.
// Depends on leso_pkg and the channel interfaces in leso_if.sv.
//
// Usage:
//   sample: valid/ready channel carrying measured (y), drive (u) and clear.
//   result: valid/ready channel carrying the updated z1, z2, z3 estimates and
//           a saturated flag. One result per sample, in order.
//   APB port: gains beta1..3, plant gain b0 and step time dt at 8*i.
// Sequencing:
//   An update runs 8 products and 7 saturating adds. Each product takes four
//   32x32 partial products through the one multiplier plus an accumulate and
//   a scale/clip step; each add is a single step. When the last add is
//   written the result register loads as soon as it is free, and the next
//   sample is taken only after that: one sample is worked on at a time.
//   A clear sample zeroes the states and skips the program; its result then
//   loads into the result register as soon as that is free.
// Reset: states go to zero and the registers to their defaults.
// Stall: a finished estimate waits in the result register while the next
//   sample is taken and worked on; the sequencer holds only if a second
//   result is ready before the first one is transferred.
`timescale 1ns / 1ps
`default_nettype none

module linear_extended_state_observer_unit #(
    parameter int STATE_WIDTH = leso_pkg::STATE_WIDTH_DEF,
    parameter int STATE_FRAC  = leso_pkg::STATE_FRAC_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    leso_sample_if.sink                              sample,
    leso_result_if.source                            result,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [leso_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [leso_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [leso_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                     pready
);

    localparam int W      = STATE_WIDTH;
    localparam int OPER_W = leso_pkg::OPER_W;
    localparam int MAG_W  = leso_pkg::MAG_W;
    localparam int LIMB_W = leso_pkg::LIMB_W;
    localparam int ACC_W  = leso_pkg::ACC_W;
    localparam int WORD_W = leso_pkg::WORD_W;
    localparam int GAIN_W = leso_pkg::GAIN_W;

    // Scaling of y (16 fraction bits) and b0*u (32 fraction bits)
    localparam int YQ_L = (STATE_FRAC >= 16) ? STATE_FRAC - 16 : 0;
    localparam int YQ_R = (STATE_FRAC >= 16) ? 0 : 16 - STATE_FRAC;
    localparam int BU_L = (STATE_FRAC >= 32) ? STATE_FRAC - 32 : 0;
    localparam int BU_R = (STATE_FRAC >= 32) ? 0 : 32 - STATE_FRAC;

    localparam logic [ACC_W-1:0] YQ_MASK   = (ACC_W'(1) << YQ_R) - ACC_W'(1);
    localparam logic [ACC_W-1:0] BU_MASK   = (ACC_W'(1) << BU_R) - ACC_W'(1);
    localparam logic [ACC_W-1:0] GAIN_MASK = (ACC_W'(1) << 16) - ACC_W'(1);
    localparam logic [ACC_W-1:0] STEP_MASK = (ACC_W'(1) << 32) - ACC_W'(1);
    localparam logic [ACC_W-1:0] LIM_POS   = (ACC_W'(1) << (W - 1)) - ACC_W'(1);

    localparam logic [W-1:0] ST_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] ST_MIN = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_POST,
        ST_ADD,
        ST_DONE
    } state_t;

    // Update program, run in order
    typedef enum logic [3:0] {
        S_YQ,   // yq = scale(y)
        S_BU,   // bu = scale(b0 * u)
        S_E,    // e  = yq - z1
        S_M1,   // t  = beta1 * e
        S_S1,   // s1 = z2 + t
        S_M2,   // t  = beta2 * e
        S_S2A,  // s2 = z3 + bu
        S_S2B,  // s2 = s2 + t
        S_M3,   // s3 = beta3 * e
        S_D1,   // t  = dt * s1
        S_Z1,   // z1 = z1 + t
        S_D2,   // t  = dt * s2
        S_Z2,   // z2 = z2 + t
        S_D3,   // t  = dt * s3
        S_Z3    // z3 = z3 + t
    } step_t;

    typedef enum logic [1:0] {
        M_YQ,
        M_BU,
        M_GAIN,
        M_STEP
    } scale_t;

    function automatic logic is_mul_step(input step_t s);
        logic r;
        unique case (s)
            S_YQ, S_BU, S_M1, S_M2, S_M3, S_D1, S_D2, S_D3: r = 1'b1;
            default:                                      r = 1'b0;
        endcase
        return r;
    endfunction

    // Control and architectural state
    state_t               state_reg;
    step_t                pc_reg;
    logic [2:0]           mcnt_reg;
    logic                 clip_reg;
    logic [W-1:0]         z1_reg, z2_reg, z3_reg;
    logic [GAIN_W-1:0]    gain_one_reg, gain_two_reg, gain_three_reg;
    logic [WORD_W-1:0]    plant_gain_reg, step_time_reg;
    logic                 out_valid_reg;
    logic [W-1:0]         out_pos_reg, out_rate_reg, out_dist_reg;
    logic                 out_sat_reg;

    // Datapath registers
    logic [WORD_W-1:0]    y_reg, u_reg;
    logic [W-1:0]         yq_reg, bu_reg, e_reg, t_reg, s1_reg, s2_reg, s3_reg;
    logic [2*LIMB_W-1:0]  prod_reg;
    logic [1:0]           psh_reg;
    logic [ACC_W-1:0]     acc_reg;

    logic                 cfg_wr;
    logic [leso_pkg::REG_IDX_W-1:0] reg_idx;
    logic                 sample_xfer;
    logic                 result_load;
    step_t                pc_next;

    // Multiplier operands
    logic [OPER_W-1:0]    opa, opb;
    logic [MAG_W-1:0]     mag_a, mag_b;
    logic                 mneg;
    scale_t               scale_mode;
    logic [LIMB_W-1:0]    limb_a, limb_b;

    // Scale and clip of the finished product
    logic [ACC_W-1:0]     q_shift, q_round, q_lim, q_mag;
    logic                 q_rem, mclip;
    logic [W-1:0]         mres;

    // Saturating adder
    logic [W-1:0]         add_a, add_b;
    logic                 add_sub;
    logic [W:0]           add_sum;
    logic                 add_ovf;
    logic [W-1:0]         add_res;

    assign cfg_wr      = psel && penable && pwrite;
    assign reg_idx     = paddr[5:3];
    assign pready      = 1'b1;
    assign sample_xfer = sample.valid && sample.ready;
    assign result_load = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);
    assign pc_next     = step_t'(pc_reg + 4'd1);

    assign sample.ready           = (state_reg == ST_IDLE);
    assign result.valid           = out_valid_reg;
    assign result.out_position    = out_pos_reg;
    assign result.out_rate        = out_rate_reg;
    assign result.out_disturbance = out_dist_reg;
    assign result.saturated       = out_sat_reg;

    always_comb
    begin
        unique case (reg_idx)
            leso_pkg::REG_GAIN_ONE:   prdata = {16'd0, gain_one_reg};
            leso_pkg::REG_GAIN_TWO:   prdata = {16'd0, gain_two_reg};
            leso_pkg::REG_GAIN_THREE: prdata = {16'd0, gain_three_reg};
            leso_pkg::REG_PLANT_GAIN: prdata = {32'd0, plant_gain_reg};
            leso_pkg::REG_STEP_TIME:  prdata = {32'd0, step_time_reg};
            default:                  prdata = '0;
        endcase
    end

    // Operand select for the shared multiplier
    always_comb
    begin
        opa        = '0;
        opb        = '0;
        scale_mode = M_GAIN;
        unique case (pc_reg)
            S_YQ:
            begin
                opa        = {{(OPER_W-WORD_W){y_reg[WORD_W-1]}}, y_reg};
                opb        = OPER_W'(1);
                scale_mode = M_YQ;
            end
            S_BU:
            begin
                opa        = {{(OPER_W-WORD_W){plant_gain_reg[WORD_W-1]}}, plant_gain_reg};
                opb        = {{(OPER_W-WORD_W){u_reg[WORD_W-1]}}, u_reg};
                scale_mode = M_BU;
            end
            S_M1:
            begin
                opa = {{(OPER_W-GAIN_W){1'b0}}, gain_one_reg};
                opb = {{(OPER_W-W){e_reg[W-1]}}, e_reg};
            end
            S_M2:
            begin
                opa = {{(OPER_W-GAIN_W){1'b0}}, gain_two_reg};
                opb = {{(OPER_W-W){e_reg[W-1]}}, e_reg};
            end
            S_M3:
            begin
                opa = {{(OPER_W-GAIN_W){1'b0}}, gain_three_reg};
                opb = {{(OPER_W-W){e_reg[W-1]}}, e_reg};
            end
            S_D1:
            begin
                opa        = {{(OPER_W-WORD_W){1'b0}}, step_time_reg};
                opb        = {{(OPER_W-W){s1_reg[W-1]}}, s1_reg};
                scale_mode = M_STEP;
            end
            S_D2:
            begin
                opa        = {{(OPER_W-WORD_W){1'b0}}, step_time_reg};
                opb        = {{(OPER_W-W){s2_reg[W-1]}}, s2_reg};
                scale_mode = M_STEP;
            end
            S_D3:
            begin
                opa        = {{(OPER_W-WORD_W){1'b0}}, step_time_reg};
                opb        = {{(OPER_W-W){s3_reg[W-1]}}, s3_reg};
                scale_mode = M_STEP;
            end
            default:
            begin
                opa        = '0;
                opb        = '0;
                scale_mode = M_GAIN;
            end
        endcase
    end

    // Sign-magnitude form; magnitudes fit 64 bits
    assign mag_a  = opa[OPER_W-1] ? (~opa[MAG_W-1:0] + MAG_W'(1)) : opa[MAG_W-1:0];
    assign mag_b  = opb[OPER_W-1] ? (~opb[MAG_W-1:0] + MAG_W'(1)) : opb[MAG_W-1:0];
    assign mneg   = opa[OPER_W-1] ^ opb[OPER_W-1];
    assign limb_a = mcnt_reg[0] ? mag_a[MAG_W-1:LIMB_W] : mag_a[LIMB_W-1:0];
    assign limb_b = mcnt_reg[1] ? mag_b[MAG_W-1:LIMB_W] : mag_b[LIMB_W-1:0];

    // Shift the exact product to state scale, round toward minus infinity, clip
    always_comb
    begin
        unique case (scale_mode)
            M_YQ:
            begin
                q_shift = (acc_reg << YQ_L) >> YQ_R;
                q_rem   = |(acc_reg & YQ_MASK);
            end
            M_BU:
            begin
                q_shift = (acc_reg << BU_L) >> BU_R;
                q_rem   = |(acc_reg & BU_MASK);
            end
            M_GAIN:
            begin
                q_shift = acc_reg >> 16;
                q_rem   = |(acc_reg & GAIN_MASK);
            end
            M_STEP:
            begin
                q_shift = acc_reg >> 32;
                q_rem   = |(acc_reg & STEP_MASK);
            end
            default:
            begin
                q_shift = '0;
                q_rem   = 1'b0;
            end
        endcase
        q_round = q_shift + {{(ACC_W-1){1'b0}}, mneg & q_rem};
        q_lim   = mneg ? LIM_POS + ACC_W'(1) : LIM_POS;
        mclip   = q_round > q_lim;
        q_mag   = mclip ? q_lim : q_round;
        mres    = mneg ? (~q_mag[W-1:0] + W'(1)) : q_mag[W-1:0];
    end

    // Operand select and saturation for the shared adder
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (pc_reg)
            S_E:
            begin
                add_a   = yq_reg;
                add_b   = z1_reg;
                add_sub = 1'b1;
            end
            S_S1:
            begin
                add_a = z2_reg;
                add_b = t_reg;
            end
            S_S2A:
            begin
                add_a = z3_reg;
                add_b = bu_reg;
            end
            S_S2B:
            begin
                add_a = s2_reg;
                add_b = t_reg;
            end
            S_Z1:
            begin
                add_a = z1_reg;
                add_b = t_reg;
            end
            S_Z2:
            begin
                add_a = z2_reg;
                add_b = t_reg;
            end
            S_Z3:
            begin
                add_a = z3_reg;
                add_b = t_reg;
            end
            default:
            begin
                add_a   = '0;
                add_b   = '0;
                add_sub = 1'b0;
            end
        endcase
        add_sum = add_sub ? ({add_a[W-1], add_a} - {add_b[W-1], add_b})
                          : ({add_a[W-1], add_a} + {add_b[W-1], add_b});
        add_ovf = add_sum[W] ^ add_sum[W-1];
        add_res = add_ovf ? (add_sum[W] ? ST_MIN : ST_MAX) : add_sum[W-1:0];
    end

    // Datapath: operand capture, partial products, intermediate results
    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            y_reg <= sample.measured;
            u_reg <= sample.drive;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= limb_a * limb_b;
            psh_reg  <= {1'b0, mcnt_reg[0]} + {1'b0, mcnt_reg[1]};
            // accumulate the partial product from the previous cycle
            if (mcnt_reg == 3'd0)
                acc_reg <= '0;
            else
                acc_reg <= acc_reg + ({{(ACC_W-2*LIMB_W){1'b0}}, prod_reg}
                                      << (LIMB_W * int'(psh_reg)));
        end
        if (state_reg == ST_POST)
        begin
            unique case (pc_reg)
                S_YQ:    yq_reg <= mres;
                S_BU:    bu_reg <= mres;
                S_M3:    s3_reg <= mres;
                default: t_reg  <= mres;
            endcase
        end
        if (state_reg == ST_ADD)
        begin
            unique case (pc_reg)
                S_E:          e_reg  <= add_res;
                S_S1:         s1_reg <= add_res;
                S_S2A, S_S2B: s2_reg <= add_res;
                default:      ;
            endcase
        end
    end

    // Sequencer, observer states, configuration and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pc_reg         <= S_YQ;
            mcnt_reg       <= '0;
            clip_reg       <= 1'b0;
            z1_reg         <= '0;
            z2_reg         <= '0;
            z3_reg         <= '0;
            gain_one_reg   <= leso_pkg::GAIN_ONE_RST;
            gain_two_reg   <= leso_pkg::GAIN_TWO_RST;
            gain_three_reg <= leso_pkg::GAIN_THREE_RST;
            plant_gain_reg <= leso_pkg::PLANT_GAIN_RST;
            step_time_reg  <= leso_pkg::STEP_TIME_RST;
            out_valid_reg  <= 1'b0;
            out_pos_reg    <= '0;
            out_rate_reg   <= '0;
            out_dist_reg   <= '0;
            out_sat_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (reg_idx)
                    leso_pkg::REG_GAIN_ONE:   gain_one_reg   <= pwdata[GAIN_W-1:0];
                    leso_pkg::REG_GAIN_TWO:   gain_two_reg   <= pwdata[GAIN_W-1:0];
                    leso_pkg::REG_GAIN_THREE: gain_three_reg <= pwdata[GAIN_W-1:0];
                    leso_pkg::REG_PLANT_GAIN: plant_gain_reg <= pwdata[WORD_W-1:0];
                    leso_pkg::REG_STEP_TIME:  step_time_reg  <= pwdata[WORD_W-1:0];
                    default:                  ;
                endcase
            end

            // drop the valid flag unless a new estimate loads in the same cycle
            if (result.valid && result.ready && !result_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (sample_xfer)
                    begin
                        clip_reg <= 1'b0;
                        mcnt_reg <= '0;
                        pc_reg   <= S_YQ;
                        if (sample.clear)
                        begin
                            z1_reg    <= '0;
                            z2_reg    <= '0;
                            z3_reg    <= '0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    // four partial products, then a final step to add the last
                    if (mcnt_reg == 3'd4)
                        state_reg <= ST_POST;
                    else
                        mcnt_reg <= mcnt_reg + 3'd1;
                end
                ST_POST, ST_ADD:
                begin
                    if (state_reg == ST_POST)
                        clip_reg <= clip_reg | mclip;
                    else
                    begin
                        clip_reg <= clip_reg | add_ovf;
                        unique case (pc_reg)
                            S_Z1:    z1_reg <= add_res;
                            S_Z2:    z2_reg <= add_res;
                            S_Z3:    z3_reg <= add_res;
                            default: ;
                        endcase
                    end
                    mcnt_reg <= '0;
                    if (pc_reg == S_Z3)
                        state_reg <= ST_DONE;
                    else
                    begin
                        pc_reg    <= pc_next;
                        state_reg <= is_mul_step(pc_next) ? ST_MUL : ST_ADD;
                    end
                end
                ST_DONE:
                begin
                    // hold until the result register is free
                    if (result_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_pos_reg   <= z1_reg;
                        out_rate_reg  <= z2_reg;
                        out_dist_reg  <= z3_reg;
                        out_sat_reg   <= clip_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
